// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ngr_pkg.sv =====
// Package for the NMEA GGA/RMC field parser: character codes, field
// positions, sentence kinds and the report struct. No dependencies.
`timescale 1ns / 1ps

package ngr_pkg;

  // magnitude limit 99999999999 needs 37 bits; signed values need 38
  localparam int MAG_W = 37;
  localparam int VAL_W = 38;
  localparam logic [MAG_W-1:0] MAG_MAX = 37'd99999999999;

  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // prefix candidates
  localparam logic [1:0] CAND_GGA  = 2'b01;
  localparam logic [1:0] CAND_RMC  = 2'b10;
  localparam logic [1:0] CAND_BOTH = 2'b11;

  // field numbers (0 is the sentence tag)
  localparam logic [4:0] FIELD_LAST    = 5'd19;
  localparam logic [4:0] GGA_LAT_FIELD = 5'd2;
  localparam logic [4:0] GGA_NS_FIELD  = 5'd3;
  localparam logic [4:0] GGA_LON_FIELD = 5'd4;
  localparam logic [4:0] GGA_EW_FIELD  = 5'd5;
  localparam logic [4:0] GGA_ALT_FIELD = 5'd9;
  localparam logic [4:0] GGA_MIN_LAST  = 5'd9;  // at least 10 fields
  localparam logic [4:0] RMC_LAT_FIELD = 5'd3;
  localparam logic [4:0] RMC_NS_FIELD  = 5'd4;
  localparam logic [4:0] RMC_LON_FIELD = 5'd5;
  localparam logic [4:0] RMC_EW_FIELD  = 5'd6;
  localparam logic [4:0] RMC_SPD_FIELD = 5'd7;
  localparam logic [4:0] RMC_MIN_LAST  = 5'd7;  // at least 8 fields

  localparam logic [1:0] SLOT_LAT = 2'd0;
  localparam logic [1:0] SLOT_LON = 2'd1;
  localparam logic [1:0] SLOT_ALT = 2'd2;
  localparam logic [1:0] SLOT_SPD = 2'd3;

  typedef enum logic [1:0] {
    KIND_GGA  = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic neg;
    logic frac;
    logic stop;
    logic seen;
  } ngr_num_flags_t;

  // what a line end hands to the top level; hemispheres already folded in
  typedef struct packed {
    logic             done;
    kind_t            kind;
    logic             lat_neg;
    logic [MAG_W-1:0] lat_mag;
    logic             lon_neg;
    logic [MAG_W-1:0] lon_mag;
    logic             alt_neg;
    logic [MAG_W-1:0] alt_mag;
    logic             spd_neg;
    logic [MAG_W-1:0] spd_mag;
  } ngr_report_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function automatic logic [7:0] gga_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h4E;  // N
      3'd3:    c = 8'h47;  // G
      3'd4:    c = 8'h47;  // G
      3'd5:    c = 8'h41;  // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rmc_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h4E;  // N
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h4D;  // M
      3'd5:    c = 8'h43;  // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ngr_scale.sv =====
// Field value scaler: pads missing fraction digits with one multiply by a
// power of ten and saturates. Depends on ngr_pkg.
`timescale 1ns / 1ps

module ngr_scale
  import ngr_pkg::*;
#(
  parameter int FRACTION_DIGITS = 5
) (
  input  logic [MAG_W-1:0]                     mag,
  input  logic [$clog2(FRACTION_DIGITS+1)-1:0] frac_cnt,
  output logic [MAG_W-1:0]                     mag_out
);
  localparam int FC_W    = $clog2(FRACTION_DIGITS + 1);
  localparam int TBL_N   = 2 ** FC_W;
  localparam int SCALE_W = $clog2(pow10(FRACTION_DIGITS) + 1);
  localparam int PROD_W  = MAG_W + SCALE_W;

  logic [SCALE_W-1:0] scale_tbl [TBL_N];
  logic [PROD_W-1:0]  prod;

  // 10^(digits still missing); unused codes scale by one
  for (genvar i = 0; i < TBL_N; i++) begin : g_tbl
    assign scale_tbl[i] = (i <= FRACTION_DIGITS) ?
                          SCALE_W'(pow10(FRACTION_DIGITS - i)) : SCALE_W'(1);
  end

  assign prod    = {{SCALE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, scale_tbl[frac_cnt]};
  assign mag_out = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];

endmodule

// ===== rtl/ngr_line.sv =====
// Line state of the parser: prefix match, field count, number accumulator,
// hemisphere flags and pending field values. Depends on ngr_pkg, ngr_scale.
`timescale 1ns / 1ps

module ngr_line
  import ngr_pkg::*;
#(
  parameter int FRACTION_DIGITS = 5,
  parameter int MAX_LINE_CHARS  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        adv,
  input  logic        enable,
  output ngr_report_t rpt
);
  localparam int LP_W = $clog2(MAX_LINE_CHARS + 1);
  localparam int FC_W = $clog2(FRACTION_DIGITS + 1);
  localparam logic [LP_W-1:0] LP_MAX    = LP_W'(MAX_LINE_CHARS);
  localparam logic [LP_W-1:0] LP_PREFIX = LP_W'(PREFIX_LEN);
  localparam logic [FC_W-1:0] FC_MAX    = FC_W'(FRACTION_DIGITS);

  logic [LP_W-1:0]  line_pos, line_pos_next;
  logic [1:0]       cand, cand_next;
  logic [4:0]       field_num, field_num_next;
  logic [MAG_W-1:0] acc, acc_next;
  ngr_num_flags_t   nf, nf_next;
  logic [FC_W-1:0]  frac_cnt, frac_cnt_next;
  logic [1:0]       hemi, hemi_next;
  logic             pend_neg [4];
  logic [MAG_W-1:0] pend_mag [4];

  logic             is_eol, is_comma, is_digit, in_line;
  logic [1:0]       cand_upd, cand_use;
  logic             slot_ok;
  logic [1:0]       slot;
  logic [1:0]       hemi_sel;
  logic [MAG_W+3:0] mac_sum;
  logic [MAG_W-1:0] mac;
  logic [MAG_W-1:0] sc_mag;
  logic             pend_wr;
  logic             eff_neg [4];
  logic [MAG_W-1:0] eff_mag [4];
  kind_t            kind;

  assign is_eol   = (ch == CH_CR) || (ch == CH_LF);
  assign is_comma = (ch == CH_COMMA);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign in_line  = (line_pos < LP_MAX);

  always_comb begin
    cand_upd = cand;
    if (line_pos < LP_PREFIX) begin
      if (ch != gga_char(line_pos[2:0])) cand_upd[0] = 1'b0;
      if (ch != rmc_char(line_pos[2:0])) cand_upd[1] = 1'b0;
    end
  end

  // a line end sees the candidates as left by the last character
  assign cand_use = is_eol ? cand : cand_upd;

  always_comb begin
    slot_ok = 1'b0;
    slot    = SLOT_LAT;
    case (cand_use)
      CAND_GGA: begin
        if (field_num == GGA_LAT_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_LAT;
        end else if (field_num == GGA_LON_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_LON;
        end else if (field_num == GGA_ALT_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_ALT;
        end
      end
      CAND_RMC: begin
        if (field_num == RMC_LAT_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_LAT;
        end else if (field_num == RMC_LON_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_LON;
        end else if (field_num == RMC_SPD_FIELD) begin
          slot_ok = 1'b1; slot = SLOT_SPD;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    hemi_sel = 2'b00;
    case (cand_upd)
      CAND_GGA: begin
        hemi_sel[0] = (field_num == GGA_NS_FIELD);
        hemi_sel[1] = (field_num == GGA_EW_FIELD);
      end
      CAND_RMC: begin
        hemi_sel[0] = (field_num == RMC_NS_FIELD);
        hemi_sel[1] = (field_num == RMC_EW_FIELD);
      end
      default: ;
    endcase
  end

  // acc*10 + digit, saturating
  assign mac_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (MAG_W+4)'(ch[3:0]);
  assign mac     = (mac_sum > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : mac_sum[MAG_W-1:0];

  ngr_scale #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scale (
    .mag     (acc),
    .frac_cnt(frac_cnt),
    .mag_out (sc_mag)
  );

  always_comb begin
    line_pos_next  = line_pos;
    cand_next      = cand;
    field_num_next = field_num;
    acc_next       = acc;
    nf_next        = nf;
    frac_cnt_next  = frac_cnt;
    hemi_next      = hemi;
    pend_wr        = 1'b0;
    if (adv) begin
      if (!is_eol) begin
        if (in_line) begin
          line_pos_next = line_pos + 1'b1;
          cand_next     = cand_upd;
          if (is_comma) begin
            pend_wr = slot_ok;
            if (field_num < FIELD_LAST) field_num_next = field_num + 1'b1;
            acc_next      = '0;
            nf_next       = '0;
            frac_cnt_next = '0;
          end else begin
            if (hemi_sel[0] && !nf.seen && ch == CH_S) hemi_next[0] = 1'b1;
            if (hemi_sel[1] && !nf.seen && ch == CH_W) hemi_next[1] = 1'b1;
            if (!nf.stop) begin
              if (is_digit) begin
                if (!nf.frac) begin
                  acc_next = mac;
                end else if (frac_cnt < FC_MAX) begin
                  acc_next      = mac;
                  frac_cnt_next = frac_cnt + 1'b1;
                end
              end else if (ch == CH_DOT && !nf.frac) begin
                nf_next.frac = 1'b1;
              end else if ((ch == CH_MINUS || ch == CH_PLUS) && !nf.seen) begin
                if (ch == CH_MINUS) nf_next.neg = 1'b1;
              end else begin
                nf_next.stop = 1'b1;
              end
            end
            nf_next.seen = 1'b1;
          end
        end
      end else if (line_pos != '0) begin
        pend_wr        = slot_ok;
        line_pos_next  = '0;
        cand_next      = CAND_BOTH;
        field_num_next = '0;
        acc_next       = '0;
        nf_next        = '0;
        frac_cnt_next  = '0;
        hemi_next      = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos  <= '0;
      cand      <= CAND_BOTH;
      field_num <= '0;
      acc       <= '0;
      nf        <= '0;
      frac_cnt  <= '0;
      hemi      <= 2'b00;
    end else begin
      line_pos  <= line_pos_next;
      cand      <= cand_next;
      field_num <= field_num_next;
      acc       <= acc_next;
      nf        <= nf_next;
      frac_cnt  <= frac_cnt_next;
      hemi      <= hemi_next;
    end
  end

  // pending values kept as sign and magnitude
  always_ff @(posedge clk) begin
    if (pend_wr) begin
      pend_neg[slot] <= nf.neg;
      pend_mag[slot] <= sc_mag;
    end
  end

  // the field closed by the line end itself bypasses the pending store
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (is_eol && slot_ok && slot == 2'(i)) begin
        eff_neg[i] = nf.neg;
        eff_mag[i] = sc_mag;
      end else begin
        eff_neg[i] = pend_neg[i];
        eff_mag[i] = pend_mag[i];
      end
    end
  end

  always_comb begin
    kind = KIND_NONE;
    if (enable && line_pos >= LP_PREFIX) begin
      if (cand == CAND_GGA && field_num >= GGA_MIN_LAST) begin
        kind = KIND_GGA;
      end else if (cand == CAND_RMC && field_num >= RMC_MIN_LAST) begin
        kind = KIND_RMC;
      end
    end
  end

  always_comb begin
    rpt.done    = is_eol && (line_pos != '0);
    rpt.kind    = kind;
    rpt.lat_neg = eff_neg[SLOT_LAT] ^ hemi[0];
    rpt.lat_mag = eff_mag[SLOT_LAT];
    rpt.lon_neg = eff_neg[SLOT_LON] ^ hemi[1];
    rpt.lon_mag = eff_mag[SLOT_LON];
    rpt.alt_neg = eff_neg[SLOT_ALT];
    rpt.alt_mag = eff_mag[SLOT_ALT];
    rpt.spd_neg = eff_neg[SLOT_SPD];
    rpt.spd_mag = eff_mag[SLOT_SPD];
  end

endmodule

// ===== rtl/nmea_gga_rmc_field_parser.sv =====
// NMEA GGA/RMC field parser, top level (depends on ngr_pkg, ngr_line,
// ngr_scale and assert_macros.svh). One received character is taken per
// transaction on the byte channel and a new one can follow in every cycle
// unless byte_stall is high; from the input register the line logic (prefix
// compare, field count, multiply-by-ten accumulate, one scaling multiply)
// updates its state. A CR or LF closing a non-empty line gives one result
// transaction, registered once the output slot is free; other characters
// give none. The result carries the sentence kind (0 GGA, 1 RMC, 2 invalid
// or ignored) and the four held values, signed fixed point with
// FRACTION_DIGITS fraction digits. Held values change only on a valid GGA
// or RMC line and stay on the outputs between results. byte_stall rises
// only when a line end waits in the input register while a previous result
// is still stalled downstream. The user writes enable (cfg_we/cfg_wdata) only
// while idle; the block does not enforce it. With it low every line is invalid.
`timescale 1ns / 1ps

module nmea_gga_rmc_field_parser
  import ngr_pkg::*;
#(
  parameter int FRACTION_DIGITS = 5,
  parameter int MAX_LINE_CHARS  = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  // character channel
  input  logic [7:0]              rx_byte,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  // result channel
  output logic [1:0]              sentence_kind,
  output logic signed [VAL_W-1:0] latitude,
  output logic signed [VAL_W-1:0] longitude,
  output logic signed [VAL_W-1:0] altitude,
  output logic signed [VAL_W-1:0] ground_speed,
  output logic                    result_valid,
  input  logic                    result_stall
);
  `include "assert_macros.svh"

  logic        enable;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_adv;
  logic        out_free;
  kind_t       kind;
  ngr_report_t rpt;

  logic signed [VAL_W-1:0] lat_new, lon_new, alt_new, spd_new;

  function automatic logic signed [VAL_W-1:0] to_val(input logic neg,
                                                      input logic [MAG_W-1:0] mag);
    logic signed [VAL_W-1:0] v;
    v = {1'b0, mag};
    return neg ? -v : v;
  endfunction

  // output slot is free when empty or being drained this cycle
  assign out_free   = !result_valid || !result_stall;
  // a character with no result always moves on; a line end waits for the slot
  assign hold_adv   = hold_valid && (!rpt.done || out_free);
  assign byte_stall = hold_valid && !hold_adv;

  ngr_line #(
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_line (
    .clk   (clk),
    .rst   (rst),
    .ch    (hold_byte),
    .adv   (hold_adv),
    .enable(enable),
    .rpt   (rpt)
  );

  always_comb begin
    lat_new = to_val(rpt.lat_neg, rpt.lat_mag);
    lon_new = to_val(rpt.lon_neg, rpt.lon_mag);
    alt_new = to_val(rpt.alt_neg, rpt.alt_mag);
    spd_new = to_val(rpt.spd_neg, rpt.spd_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      kind         <= KIND_NONE;
      latitude     <= '0;
      longitude    <= '0;
      altitude     <= '0;
      ground_speed <= '0;
    end else begin
      if (cfg_we) enable <= cfg_wdata;

      if (byte_valid && !byte_stall) begin
        hold_valid <= 1'b1;
      end else if (hold_adv) begin
        hold_valid <= 1'b0;
      end

      if (hold_adv && rpt.done) begin
        result_valid <= 1'b1;
        kind         <= rpt.kind;
        case (rpt.kind)
          KIND_GGA: begin
            latitude  <= lat_new;
            longitude <= lon_new;
            altitude  <= alt_new;
          end
          KIND_RMC: begin
            latitude     <= lat_new;
            longitude    <= lon_new;
            ground_speed <= spd_new;
          end
          default: ;
        endcase
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // character payload, no reset needed
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) hold_byte <= rx_byte;
  end

  assign sentence_kind = 2'(kind);

  `ASSERT_SAME(a_result_has_slot, hold_adv && rpt.done, out_free, "result issued into a full output")
  `ASSERT_SAME(a_disabled_invalid, hold_valid && rpt.done && !enable, rpt.kind == KIND_NONE, "line accepted while disabled")
  `ASSERT_NEXT(a_held_only_on_fix, !(hold_adv && rpt.done && rpt.kind != KIND_NONE), $stable(latitude) && $stable(longitude) && $stable(altitude) && $stable(ground_speed), "held value changed without a valid line")
  `ASSERT_NEXT(a_gga_keeps_speed, hold_adv && rpt.done && rpt.kind == KIND_GGA, $stable(ground_speed), "GGA line touched ground speed")

endmodule

// ===== verif/tb_nmea_gga_rmc_field_parser.sv =====
// Testbench for nmea_gga_rmc_field_parser: directed and random character streams,
// checked against a cycle-free behavioural predictor of the held fix values.
// Depends on ngr_pkg and the parser RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_nmea_gga_rmc_field_parser;
  import ngr_pkg::*;

  localparam int FRAC_DIGITS    = 5;
  localparam int LINE_MAX       = 128;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side
  localparam int PRESSURE_HOLD  = 400;   // long receiver hold-off, in cycles

  localparam logic [8*PREFIX_LEN-1:0] GGA_TAG = "$GNGGA";
  localparam logic [8*PREFIX_LEN-1:0] RMC_TAG = "$GNRMC";

  // hemisphere marks gathered during a line
  localparam logic [1:0] SOUTH_BIT = 2'b01;
  localparam logic [1:0] WEST_BIT  = 2'b10;

  typedef logic signed [VAL_W-1:0] fixed_t;

  // one result transaction: sentence kind plus the four held values
  typedef struct {
    kind_t  kind;
    longint vals [4];
  } fix_report_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_wdata;
  logic [7:0]   rx_byte;
  logic         byte_valid;
  logic         byte_stall;
  logic [1:0]   sentence_kind;
  fixed_t       latitude;
  fixed_t       longitude;
  fixed_t       altitude;
  fixed_t       ground_speed;
  logic         result_valid;
  logic         result_stall;

  nmea_gga_rmc_field_parser #(
    .FRACTION_DIGITS(FRAC_DIGITS),
    .MAX_LINE_CHARS (LINE_MAX)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (rx_byte),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .sentence_kind(sentence_kind),
    .latitude     (latitude),
    .longitude    (longitude),
    .altitude     (altitude),
    .ground_speed (ground_speed),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the line parser and the held fix
  // ---------------------------------------------------------------------------
  bit          parse_en;
  int          line_len;
  logic [1:0]  tag_cand;
  int          field_idx;
  longint unsigned digits_acc;
  bit          num_neg, num_frac, num_stop, num_seen;
  int          frac_digits;
  longint      staged [4];
  logic [1:0]  south_west;
  longint      held [4];

  fix_report_t due_reports [$];   // results predicted but not yet seen
  int          errors;
  int          chars_sent;
  int          lines_reported;

  // stimulus pacing
  bit          calm_tx;
  bit          calm_rx;
  int          hold_off_len;
  int          idle_cycles;

  string       val_name [4] = '{"latitude", "longitude", "altitude", "ground_speed"};

  // multiply-by-ten accumulate, saturating at the magnitude limit
  function automatic longint unsigned mac10(input longint unsigned acc, input int unsigned d);
    longint unsigned cap;
    cap = MAG_MAX;
    if (acc > (cap - d) / 10) return cap;
    return acc * 10 + d;
  endfunction

  function automatic void clear_number();
    digits_acc  = 0;
    num_neg     = 1'b0;
    num_frac    = 1'b0;
    num_stop    = 1'b0;
    num_seen    = 1'b0;
    frac_digits = 0;
  endfunction

  function automatic void clear_line();
    line_len   = 0;
    tag_cand   = CAND_BOTH;
    field_idx  = 0;
    south_west = 2'b00;
    clear_number();
  endfunction

  // which held value the current field feeds, -1 for none
  function automatic int slot_of_field();
    if (tag_cand == CAND_GGA) begin
      if (field_idx == GGA_LAT_FIELD) return SLOT_LAT;
      if (field_idx == GGA_LON_FIELD) return SLOT_LON;
      if (field_idx == GGA_ALT_FIELD) return SLOT_ALT;
    end else if (tag_cand == CAND_RMC) begin
      if (field_idx == RMC_LAT_FIELD) return SLOT_LAT;
      if (field_idx == RMC_LON_FIELD) return SLOT_LON;
      if (field_idx == RMC_SPD_FIELD) return SLOT_SPD;
    end
    return -1;
  endfunction

  function automatic logic [1:0] hemisphere_of_field();
    if (tag_cand == CAND_GGA) begin
      if (field_idx == GGA_NS_FIELD) return SOUTH_BIT;
      if (field_idx == GGA_EW_FIELD) return WEST_BIT;
    end else if (tag_cand == CAND_RMC) begin
      if (field_idx == RMC_NS_FIELD) return SOUTH_BIT;
      if (field_idx == RMC_EW_FIELD) return WEST_BIT;
    end
    return 2'b00;
  endfunction

  // pad the fraction out to FRAC_DIGITS and stage the signed value
  function automatic void close_field();
    int slot;
    longint unsigned m;
    slot = slot_of_field();
    if (slot < 0) return;
    m = digits_acc;
    for (int f = frac_digits; f < FRAC_DIGITS; f++) m = mac10(m, 0);
    staged[slot] = num_neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [1:0] h;
    if (c == CH_COMMA) begin
      close_field();
      if (field_idx < FIELD_LAST) field_idx++;
      clear_number();
      return;
    end
    // only the first character of a hemisphere field counts
    h = hemisphere_of_field();
    if (h != 2'b00 && !num_seen) begin
      if ((h == SOUTH_BIT && c == CH_S) || (h == WEST_BIT && c == CH_W)) south_west |= h;
    end
    if (!num_stop) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!num_frac) begin
          digits_acc = mac10(digits_acc, c - CH_ZERO);
        end else if (frac_digits < FRAC_DIGITS) begin
          digits_acc = mac10(digits_acc, c - CH_ZERO);
          frac_digits++;
        end
      end else if (c == CH_DOT && !num_frac) begin
        num_frac = 1'b1;
      end else if ((c == CH_MINUS || c == CH_PLUS) && !num_seen) begin
        if (c == CH_MINUS) num_neg = 1'b1;
      end else begin
        num_stop = 1'b1;
      end
    end
    num_seen = 1'b1;
  endfunction

  // advance the predictor by one accepted character; a line end queues a report
  function automatic void parse_char(input logic [7:0] c);
    fix_report_t r;
    if (c != CH_CR && c != CH_LF) begin
      if (line_len < LINE_MAX) begin
        if (line_len < PREFIX_LEN) begin
          if (GGA_TAG[8*(PREFIX_LEN-1-line_len) +: 8] != c) tag_cand &= ~CAND_GGA;
          if (RMC_TAG[8*(PREFIX_LEN-1-line_len) +: 8] != c) tag_cand &= ~CAND_RMC;
        end
        line_len++;
        take_char(c);
      end
      return;
    end
    if (line_len == 0) return;   // empty line: no transaction
    close_field();
    r.kind = KIND_NONE;
    if (parse_en && line_len >= PREFIX_LEN) begin
      if (tag_cand == CAND_GGA && field_idx >= GGA_MIN_LAST) begin
        held[SLOT_LAT] = south_west[0] ? -staged[SLOT_LAT] : staged[SLOT_LAT];
        held[SLOT_LON] = south_west[1] ? -staged[SLOT_LON] : staged[SLOT_LON];
        held[SLOT_ALT] = staged[SLOT_ALT];
        r.kind = KIND_GGA;
      end else if (tag_cand == CAND_RMC && field_idx >= RMC_MIN_LAST) begin
        held[SLOT_LAT] = south_west[0] ? -staged[SLOT_LAT] : staged[SLOT_LAT];
        held[SLOT_LON] = south_west[1] ? -staged[SLOT_LON] : staged[SLOT_LON];
        held[SLOT_SPD] = staged[SLOT_SPD];
        r.kind = KIND_RMC;
      end
    end
    clear_line();
    r.vals = held;
    due_reports.push_back(r);
    lines_reported++;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, pacing, the two channel drivers, result checker and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one character transaction; valid stays high into the next call unless a gap follows
  task automatic send_char(input logic [7:0] b);
    int gap;
    gap = calm_tx ? 0 : pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte    <= b;
    do @(posedge clk); while (byte_stall);
    chars_sent++;
    parse_char(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_char(CH_CR);
  endtask

  // receiver: random stall runs, calm stretches, and a long hold-off on request
  initial begin : result_side
    int   len;
    logic hold;
    calm_rx      = 1'b0;
    hold_off_len = 0;
    forever begin
      if (hold_off_len > 0) begin
        hold         = 1'b1;
        len          = hold_off_len;
        hold_off_len = 0;
      end else if (calm_rx) begin
        hold = 1'b0;
        len  = 1;
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        len  = 1 + pick_gap();
      end
      result_stall <= hold;
      repeat (len) @(posedge clk);
      if ($urandom_range(0, 149) == 0) calm_rx = !calm_rx;
    end
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    fix_report_t want;
    fixed_t      got [4];
    if (!rst && result_valid && !result_stall) begin
      got[0] = latitude;
      got[1] = longitude;
      got[2] = altitude;
      got[3] = ground_speed;
      if (due_reports.size() == 0) begin
        $error("result with none outstanding: kind %0d", sentence_kind);
        errors++;
      end else begin
        want = due_reports.pop_front();
        if (sentence_kind !== want.kind) begin
          $error("sentence_kind: expected %0d, got %0d", want.kind, sentence_kind);
          errors++;
        end
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== fixed_t'(want.vals[i])) begin
            $error("%s: expected %0d, got %0d", val_name[i], fixed_t'(want.vals[i]), got[i]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: too long without a transaction on either channel ends the run
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // drop valid, let every predicted result arrive, then let the pipe go idle
  task automatic settle();
    byte_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // only called once settled
  task automatic write_enable(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    parse_en = v;
  endtask

  task automatic send_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return;   // empty field reads as zero
    if (r < 15) send_char(CH_MINUS);
    else if (r < 20) send_char(CH_PLUS);
    // mostly short magnitudes, occasionally long enough to saturate
    repeat (($urandom_range(0, 29) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5))
      send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 9) < 7) begin
      send_char(CH_DOT);
      repeat ($urandom_range(0, 8)) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    // occasional stray character that stops the number, then trailing digits
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 4))
        0: send_char(CH_DOT);
        1: send_char(CH_MINUS);
        2: send_char(CH_PLUS);
        3: send_char("A");
        default: send_char(" ");
      endcase
      repeat ($urandom_range(0, 3)) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic send_hemisphere();
    case ($urandom_range(0, 7))
      0: send_char("N");
      1: send_char(CH_S);
      2: send_char("E");
      3: send_char(CH_W);
      4: ;
      5: send_text("SX");
      6: send_text("nW");
      default: send_char(8'($urandom_range(8'h21, 8'h7E)));
    endcase
  endtask

  // mostly well-formed GGA/RMC with random content; some broken tags and raw noise
  task automatic send_random_sentence();
    int pick, nfields, lat_f, ns_f, lon_f, ew_f, third_f;
    bit is_gga;
    pick    = $urandom_range(0, 99);
    calm_tx = ($urandom_range(0, 3) == 0);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 24)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_CR);
      return;
    end
    is_gga  = (pick < 42) || (pick >= 84 && pick < 88);
    lat_f   = is_gga ? GGA_LAT_FIELD : RMC_LAT_FIELD;
    ns_f    = is_gga ? GGA_NS_FIELD  : RMC_NS_FIELD;
    lon_f   = is_gga ? GGA_LON_FIELD : RMC_LON_FIELD;
    ew_f    = is_gga ? GGA_EW_FIELD  : RMC_EW_FIELD;
    third_f = is_gga ? GGA_ALT_FIELD : RMC_SPD_FIELD;
    if (pick >= 84) begin
      // tag broken in its last character
      send_text(is_gga ? "$GNGG" : "$GNRM");
      send_char(8'($urandom_range(8'h21, 8'h7E)));
    end else begin
      send_text(is_gga ? "$GNGGA" : "$GNRMC");
      if ($urandom_range(0, 19) == 0) send_char("X");
    end
    nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : (is_gga ? 14 : 12);
    for (int k = 1; k <= nfields; k++) begin
      send_char(CH_COMMA);
      if (k == lat_f || k == lon_f || k == third_f) begin
        send_number();
      end else if (k == ns_f || k == ew_f) begin
        send_hemisphere();
      end else begin
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(8'h21, 8'h7E)));
      end
    end
    // a few lines run past the line limit
    if ($urandom_range(0, 39) == 0)
      repeat ($urandom_range(100, 160)) send_char(8'($urandom_range(CH_ZERO, CH_NINE)));
    case ($urandom_range(0, 4))
      0, 1: send_char(CH_CR);
      2: send_char(CH_LF);
      default: begin
        send_char(CH_CR);
        send_char(CH_LF);
      end
    endcase
  endtask

  task automatic run_random(input int n_chars, input int n_results);
    int c0, r0;
    c0 = chars_sent;
    r0 = lines_reported;
    while (chars_sent - c0 < n_chars || lines_reported - r0 < n_results)
      send_random_sentence();
    calm_tx = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // enable is low out of reset: a good sentence still reports invalid
  task automatic test_enable_gate();
    send_line("$GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    settle();
    write_enable(1'b1);
    send_line("$GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_char(CH_LF);   // CR LF: the LF closes an empty line, no transaction
  endtask

  task automatic test_basic_sentences();
    send_line("$GNRMC,123519,A,4807.038,S,01131.000,W,022.4,084.4,230394,003.1,W*6A");
    send_line("$GNGGA,,1234.56789,S,00012.5,W,,,,-12.3");   // exactly ten fields
    send_line("$GNGGA,,1,N,2,E,,,");                        // nine fields
    send_line("$GNRMC,,,1,N,2,E");                          // seven fields
  endtask

  task automatic test_tag_matching();
    send_line("$GN");                                // short line
    send_line("$GNGG");
    send_line("$GNGGAX,,1.5,N,2.5,E,,,,3.5");        // only six characters compared
    send_line("$GPGGA,,1,N,2,E,,,,3");
    send_line("$GNRMX,,,1,N,2,E,3");
  endtask

  task automatic test_number_forms();
    // sign in the field plus S cancels; second dot and letters stop the number
    send_line("$GNGGA,,-0012.5,S,+99.1.2,W,,,,12a34");
    // late sign stops, only first hemisphere character counts, truncated fraction
    send_line("$GNRMC,,,1-2,NS,1.123456789,SX,,x5");
    send_line("$GNRMC,,,.5,s,-.,W,+");
  endtask

  task automatic test_saturation();
    send_line("$GNGGA,,999999.99999,S,99999999999999,W,,,,-99999999999999.9");
    send_line("$GNRMC,,,999999.999999,N,0.00001,E,99999.999999999");
  endtask

  task automatic test_line_limits();
    // more than twenty fields: later commas merge into the last one
    send_line("$GNRMC,,,12.5,S,7.25,W,3.75,,,,,,,,,,,,,,,,,,,9");
    // commas past the line limit are ignored, so too few fields are seen
    send_text("$GNGGA,");
    repeat (140) send_char("1");
    send_line(",2,N,3,E,,,,4");
    // long altitude field runs past the limit, rest of the line ignored
    send_text("$GNGGA,,1,N,2,E,,,,");
    repeat (120) send_char("9");
    send_char(CH_CR);
    // raw bytes at the edges of the character range
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(CH_LF);
  endtask

  // receiver holds off while short lines keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    hold_off_len = PRESSURE_HOLD;
    while (hold_off_len != 0) @(posedge clk);
    calm_tx = 1'b1;
    repeat (30) send_line("$GN");
    calm_tx = 1'b0;
  endtask

  task automatic test_random_enabled();
    run_random(380, 3);
  endtask

  task automatic test_random_disabled();
    settle();
    write_enable(1'b0);
    run_random(100, 1);
    settle();
    write_enable(1'b1);
  endtask

  task automatic test_random_reenabled();
    run_random(160, 2);
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 1'b0;
    rx_byte    <= 8'h00;
    byte_valid <= 1'b0;
    errors         = 0;
    chars_sent     = 0;
    lines_reported = 0;
    calm_tx        = 1'b0;
    parse_en       = 1'b0;
    for (int i = 0; i < 4; i++) begin
      staged[i] = 0;
      held[i]   = 0;
    end
    clear_line();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_enable_gate();
    test_basic_sentences();
    test_tag_matching();
    test_number_forms();
    test_saturation();
    test_line_limits();
    test_backpressure();
    test_random_enabled();
    test_random_disabled();
    test_random_reenabled();

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ngr_pkg.sv
rtl/ngr_scale.sv
rtl/ngr_line.sv
rtl/nmea_gga_rmc_field_parser.sv
verif/tb_nmea_gga_rmc_field_parser.sv
